[src/can_frame_to_ascii_hex_assert.svh]
// Assertion macros shared by the CAN frame text serializer.
`ifndef CAN_FRAME_TO_ASCII_HEX_ASSERT_SVH
`define CAN_FRAME_TO_ASCII_HEX_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property that is ignored while reset is asserted.
`define CFAH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("cfah assertion failed");
// Checked property that is also evaluated during reset.
`define CFAH_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfah reset assertion failed");
`else
`define CFAH_ASSERT(lbl, clk, rstn, prop)
`define CFAH_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[src/cfah_pkg.sv]
// Types, character constants and the hex digit helper of the CAN frame serializer.
`timescale 1ns / 1ps
package cfah_pkg;

    typedef struct packed {
        logic [28:0] identifier;
        logic        remote_request;
        logic        extended_frame;
        logic [3:0]  data_length;
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
        logic [7:0]  byte_5;
        logic [7:0]  byte_6;
        logic [7:0]  byte_7;
    } cfah_frame_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last_character;
    } cfah_result_t;

    localparam logic [6:0] CHAR_I    = 7'h49;
    localparam logic [6:0] CHAR_R    = 7'h52;
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;
    localparam logic [6:0] CHAR_NUL  = 7'h00;

    localparam logic [3:0] MAX_DATA  = 4'd8;
    localparam logic [3:0] HEX_TEN   = 4'hA;

    // Text positions of the fixed fields.
    localparam logic [4:0] POS_START = 5'd0;
    localparam logic [4:0] POS_FLAG  = 5'd9;
    localparam logic [4:0] POS_LEN   = 5'd10;
    localparam logic [4:0] POS_DATA  = 5'd11;

    // Register index decoded from paddr[2].
    localparam logic REG_EXT_ID_SUPPORT = 1'b0;

    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        logic [6:0] c;
        if (n < HEX_TEN) begin
            c = CHAR_ZERO + {3'b000, n};
        end else begin
            c = CHAR_A + {3'b000, n - HEX_TEN};
        end
        return c;
    endfunction

endpackage

[src/can_frame_to_ascii_hex.sv]
// CAN frame to ASCII hex text serializer with its configuration register.
`timescale 1ns / 1ps
`include "can_frame_to_ascii_hex_assert.svh"
// One accepted frame is held in a frame register and read out as text, one
// character per cycle while m_ready allows, through a registered output stage:
// 'I', eight identifier hex digits (upper four NUL if extended_id_support is 0),
// the flag character, the length digit and two digits per data byte, up to
// eight bytes, as the position counter over the frame register steps. The next
// frame is accepted in the cycle its predecessor's final character moves into
// the output register, so frames follow without a gap while m_ready is high.
// Register extended_id_support lies at address 0 (reset 1); write it only
// while the block is idle.
module can_frame_to_ascii_hex
    import cfah_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cfah_frame_t        s_frame,
    output logic               m_valid,
    input  logic               m_ready,
    output cfah_result_t       m_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        ext_support_reg;
    cfah_frame_t frame_reg;
    logic        busy_reg;
    logic [4:0]  pos_reg;
    logic        m_valid_reg;
    logic [6:0]  char_reg;
    logic        last_reg;

    logic        load_out;
    logic        last_pos;
    logic [3:0]  len_sat;
    logic [4:0]  end_pos;
    logic [6:0]  char_next;
    logic [31:0] id_wide;
    logic [2:0]  nib_idx;
    logic [4:0]  data_off;
    logic [7:0]  data_bytes [8];
    logic [7:0]  cur_byte;
    logic        s_accept;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_EXT_ID_SUPPORT) ? {31'd0, ext_support_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_support_reg <= 1'b1;
        end else if (cfg_write && paddr[2] == REG_EXT_ID_SUPPORT) begin
            ext_support_reg <= pwdata[0];
        end
    end

    assign len_sat  = (frame_reg.data_length > MAX_DATA) ? MAX_DATA : frame_reg.data_length;
    assign end_pos  = POS_LEN + {len_sat, 1'b0};
    assign last_pos = (pos_reg == end_pos);
    assign load_out = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !busy_reg || (load_out && last_pos);
    assign s_accept = s_valid && s_ready;

    assign id_wide  = {3'b000, frame_reg.identifier};
    assign nib_idx  = 3'(4'd8 - pos_reg[3:0]);
    assign data_off = pos_reg - POS_DATA;

    always_comb begin
        data_bytes[0] = frame_reg.byte_0;
        data_bytes[1] = frame_reg.byte_1;
        data_bytes[2] = frame_reg.byte_2;
        data_bytes[3] = frame_reg.byte_3;
        data_bytes[4] = frame_reg.byte_4;
        data_bytes[5] = frame_reg.byte_5;
        data_bytes[6] = frame_reg.byte_6;
        data_bytes[7] = frame_reg.byte_7;
    end

    assign cur_byte = data_bytes[data_off[3:1]];

    always_comb begin
        priority if (pos_reg == POS_START) begin
            char_next = CHAR_I;
        end else if (pos_reg < POS_FLAG) begin
            // Positions 1 to 4 carry the upper identifier nibbles.
            if (pos_reg < 5'd5 && !ext_support_reg) begin
                char_next = CHAR_NUL;
            end else begin
                char_next = hex_digit(id_wide[{nib_idx, 2'b00} +: 4]);
            end
        end else if (pos_reg == POS_FLAG) begin
            char_next = CHAR_R + {6'd0, frame_reg.remote_request}
                      + {5'd0, frame_reg.extended_frame & ext_support_reg, 1'b0};
        end else if (pos_reg == POS_LEN) begin
            char_next = CHAR_ZERO + {3'b000, len_sat};
        end else begin
            char_next = data_off[0] ? hex_digit(cur_byte[3:0]) : hex_digit(cur_byte[7:4]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_START;
        end else if (s_accept) begin
            busy_reg <= 1'b1;
            pos_reg  <= POS_START;
        end else if (load_out && last_pos) begin
            busy_reg <= 1'b0;
        end else if (load_out) begin
            pos_reg <= pos_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            frame_reg <= s_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            char_reg <= char_next;
            last_reg <= last_pos;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_result.character      = char_reg;
    assign m_result.last_character = last_reg;

    `CFAH_ASSERT(a_accept_restarts, aclk, aresetn, s_accept |=> (busy_reg && pos_reg == POS_START))
    `CFAH_ASSERT(a_pos_in_range, aclk, aresetn, busy_reg |-> (pos_reg <= end_pos))
    `CFAH_ASSERT(a_last_marked, aclk, aresetn, (load_out && last_pos) |=> (m_valid_reg && last_reg))
    `CFAH_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (!m_valid_reg && !busy_reg))

endmodule
